// ===== rtl/pbsr_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, constants and register codes of the balance speed regulator.
package pbsr_pkg;

    localparam int SUM_WIDTH   = 32;
    localparam int MAX_RUN     = 1024;
    localparam int COUNT_W     = $clog2(MAX_RUN + 1);
    localparam int SAMPLE_W    = 16;
    localparam int ERROR_W     = SAMPLE_W + 1;
    localparam int DELTA_W     = ERROR_W + 1;
    localparam int GAIN_W      = 24;
    localparam int SETPOINT_W  = 16;
    localparam int PERTURB_W   = 12;
    localparam int PLEN_W      = 10;
    localparam int LIMIT_W     = 11;
    localparam int SPEED_W     = 12;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int FRAC_W      = 8;

    localparam int PROD_I_W = GAIN_W + SUM_WIDTH;
    localparam int PROD_P_W = GAIN_W + ERROR_W;
    localparam int PROD_D_W = GAIN_W + DELTA_W;
    localparam int ACC_W    = PROD_I_W + 1;
    localparam int CMD_W    = ACC_W - FRAC_W + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic signed [GAIN_W-1:0]     GAIN_P_RESET   = -24'sd768;
    localparam logic signed [GAIN_W-1:0]     GAIN_D_RESET   = -24'sd51200;
    localparam logic signed [GAIN_W-1:0]     GAIN_I_RESET   = 24'sd0;
    localparam logic signed [SETPOINT_W-1:0] SETPOINT_RESET = 16'sd0;
    localparam logic signed [PERTURB_W-1:0]  PERTURB_RESET  = 12'sd100;
    localparam logic [PLEN_W-1:0]            PLEN_RESET     = 10'd128;
    localparam logic [LIMIT_W-1:0]           LIMIT_RESET    = 11'd1100;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_D   = 3'd1,
        REG_GAIN_I   = 3'd2,
        REG_SETPOINT = 3'd3,
        REG_PERTURB  = 3'd4,
        REG_PLEN     = 3'd5,
        REG_LIMIT    = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_sample;
        logic                       first_of_run;
    } in_word_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] motor_speed;
        logic                      clamped;
        logic                      perturbed;
    } out_word_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0]     gain_proportional;
        logic signed [GAIN_W-1:0]     gain_derivative;
        logic signed [GAIN_W-1:0]     gain_integral;
        logic signed [SETPOINT_W-1:0] setpoint;
        logic signed [PERTURB_W-1:0]  perturbation;
        logic [PLEN_W-1:0]            perturb_length;
        logic [LIMIT_W-1:0]           speed_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERROR_W-1:0]   error;
        logic signed [DELTA_W-1:0]   delta;
        logic signed [SUM_WIDTH-1:0] sum;
        logic                        perturbed;
    } work_t;

endpackage

// ===== rtl/pid_balance_speed_regulator.sv =====
`timescale 1ns / 1ps
// Top level: PID balance speed regulator with perturbation and output clamp.
//
// Takes one accelerometer sample word per cycle while full is low and returns one speed word
// per sample, in order. The front end updates the run state (previous error, saturating
// integral, sample count) as a sample is pushed and passes the error terms through a four-word
// queue to the back end, which forms the three gain products, sums them, shifts the sum and
// adds the perturbation, and clamps, one stage each. Full rises only when the result side
// stalls long enough for four words to back up in the queue. Write configuration only while
// no words are in flight.
module pid_balance_speed_regulator
    import pbsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  in_word_t               item,
    output logic                   empty,
    input  logic                   pop,
    output out_word_t              result,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    work_t front_word;
    work_t q_word;
    logic  accept;
    logic  q_full;
    logic  q_valid;
    logic  q_rd;

    assign accept = push && !q_full;
    assign full   = q_full;

    pbsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbsr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (item),
        .work   (front_word)
    );

    pbsr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (accept),
        .wdata (front_word),
        .rd    (q_rd),
        .full  (q_full),
        .valid (q_valid),
        .rdata (q_word)
    );

    pbsr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_word  (q_word),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

// ===== rtl/pbsr_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file of the balance speed regulator.
module pbsr_cfg
    import pbsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GAIN_P:   cfg_next.gain_proportional = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   cfg_next.gain_derivative   = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   cfg_next.gain_integral     = cfg_data[GAIN_W-1:0];
                REG_SETPOINT: cfg_next.setpoint          = cfg_data[SETPOINT_W-1:0];
                REG_PERTURB:  cfg_next.perturbation      = cfg_data[PERTURB_W-1:0];
                REG_PLEN:     cfg_next.perturb_length    = cfg_data[PLEN_W-1:0];
                REG_LIMIT:    cfg_next.speed_limit       = cfg_data[LIMIT_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_proportional <= GAIN_P_RESET;
            cfg_reg.gain_derivative   <= GAIN_D_RESET;
            cfg_reg.gain_integral     <= GAIN_I_RESET;
            cfg_reg.setpoint          <= SETPOINT_RESET;
            cfg_reg.perturbation      <= PERTURB_RESET;
            cfg_reg.perturb_length    <= PLEN_RESET;
            cfg_reg.speed_limit       <= LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pbsr_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts samples, keeps the run state and forms error terms.
module pbsr_front
    import pbsr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     accept,
    input  in_word_t item,
    output work_t    work
);

    localparam logic signed [SUM_WIDTH:0] SUM_MAX = (SUM_WIDTH+1)'((64'sd1 <<< (SUM_WIDTH-1)) - 1);
    localparam logic signed [SUM_WIDTH:0] SUM_MIN = -SUM_MAX - (SUM_WIDTH+1)'(1);

    logic signed [ERROR_W-1:0]   prev_error_reg;
    logic signed [ERROR_W-1:0]   prev_error_next;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_next;
    logic [COUNT_W-1:0]          count_reg;
    logic [COUNT_W-1:0]          count_next;

    logic signed [ERROR_W-1:0]   prev_base;
    logic signed [SUM_WIDTH-1:0] sum_base;
    logic [COUNT_W-1:0]          count_base;
    logic signed [ERROR_W-1:0]   error;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;

    always_comb
    begin
        prev_base  = item.first_of_run ? '0 : prev_error_reg;
        sum_base   = item.first_of_run ? '0 : error_sum_reg;
        count_base = item.first_of_run ? '0 : count_reg;

        error    = ERROR_W'(item.accel_sample) - ERROR_W'(cfg.setpoint);
        sum_wide = (SUM_WIDTH+1)'(sum_base) + (SUM_WIDTH+1)'(error);
        if (sum_wide > SUM_MAX)
            sum_sat = SUM_MAX[SUM_WIDTH-1:0];
        else if (sum_wide < SUM_MIN)
            sum_sat = SUM_MIN[SUM_WIDTH-1:0];
        else
            sum_sat = sum_wide[SUM_WIDTH-1:0];

        work.error     = error;
        work.delta     = DELTA_W'(error) - DELTA_W'(prev_base);
        work.sum       = sum_sat;
        work.perturbed = count_base < COUNT_W'(cfg.perturb_length);

        prev_error_next = prev_error_reg;
        error_sum_next  = error_sum_reg;
        count_next      = count_reg;
        if (accept)
        begin
            prev_error_next = error;
            error_sum_next  = sum_sat;
            count_next      = (count_base < COUNT_W'(MAX_RUN)) ? count_base + 1'b1
                                                               : count_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            error_sum_reg  <= '0;
            count_reg      <= '0;
        end
        else
        begin
            prev_error_reg <= prev_error_next;
            error_sum_reg  <= error_sum_next;
            count_reg      <= count_next;
        end
    end

endmodule

// ===== rtl/pbsr_queue.sv =====
`timescale 1ns / 1ps
// Short queue of error-term words between the front and back ends.
module pbsr_queue
    import pbsr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr,
    input  work_t wdata,
    input  logic  rd,
    output logic  full,
    output logic  valid,
    output work_t rdata
);

    work_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wptr_reg;
    logic [QUEUE_AW-1:0]  wptr_next;
    logic [QUEUE_AW-1:0]  rptr_reg;
    logic [QUEUE_AW-1:0]  rptr_next;
    logic [QUEUE_AW:0]    count_reg;
    logic [QUEUE_AW:0]    count_next;

    always_comb
    begin
        wptr_next  = wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg + (QUEUE_AW+1)'(wr) - (QUEUE_AW+1)'(rd);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    assign full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign valid = count_reg != '0;
    assign rdata = mem[rptr_reg];

endmodule

// ===== rtl/pbsr_back.sv =====
`timescale 1ns / 1ps
// Back end: gain products, sum, perturbation and clamp, ending in the result register.
module pbsr_back
    import pbsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  work_t     q_word,
    output logic      q_rd,
    input  logic      pop,
    output logic      empty,
    output out_word_t result
);

    logic                        advance;

    logic                        s1_valid_reg;
    logic signed [PROD_I_W-1:0]  s1_prod_i_reg;
    logic signed [PROD_P_W-1:0]  s1_prod_p_reg;
    logic signed [PROD_D_W-1:0]  s1_prod_d_reg;
    logic                        s1_pert_reg;

    logic                        s2_valid_reg;
    logic signed [ACC_W-1:0]     s2_acc_reg;
    logic                        s2_pert_reg;

    logic                        s3_valid_reg;
    logic signed [CMD_W-1:0]     s3_cmd_reg;
    logic                        s3_pert_reg;

    logic                        s4_valid_reg;
    out_word_t                   s4_word_reg;

    logic signed [PROD_I_W-1:0]  s1_prod_i_next;
    logic signed [PROD_P_W-1:0]  s1_prod_p_next;
    logic signed [PROD_D_W-1:0]  s1_prod_d_next;
    logic signed [ACC_W-1:0]     s2_acc_next;
    logic signed [CMD_W-1:0]     s3_cmd_next;
    logic signed [CMD_W-1:0]     lim_pos;
    logic signed [CMD_W-1:0]     lim_neg;
    out_word_t                   s4_word_next;

    assign advance = !s4_valid_reg || pop;
    assign q_rd    = advance && q_valid;

    always_comb
    begin
        s1_prod_i_next = PROD_I_W'(cfg.gain_integral) * PROD_I_W'(q_word.sum);
        s1_prod_p_next = PROD_P_W'(cfg.gain_proportional) * PROD_P_W'(q_word.error);
        s1_prod_d_next = PROD_D_W'(cfg.gain_derivative) * PROD_D_W'(q_word.delta);

        s2_acc_next = ACC_W'(s1_prod_i_reg) + ACC_W'(s1_prod_p_reg) + ACC_W'(s1_prod_d_reg);

        s3_cmd_next = CMD_W'($signed(s2_acc_reg[ACC_W-1:FRAC_W]))
                    + (s2_pert_reg ? CMD_W'(cfg.perturbation) : '0);

        lim_pos = CMD_W'($signed({1'b0, cfg.speed_limit}));
        lim_neg = -lim_pos;
        s4_word_next.perturbed = s3_pert_reg;
        if (s3_cmd_reg > lim_pos)
        begin
            s4_word_next.motor_speed = lim_pos[SPEED_W-1:0];
            s4_word_next.clamped     = 1'b1;
        end
        else if (s3_cmd_reg < lim_neg)
        begin
            s4_word_next.motor_speed = lim_neg[SPEED_W-1:0];
            s4_word_next.clamped     = 1'b1;
        end
        else
        begin
            s4_word_next.motor_speed = s3_cmd_reg[SPEED_W-1:0];
            s4_word_next.clamped     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_prod_i_reg <= s1_prod_i_next;
            s1_prod_p_reg <= s1_prod_p_next;
            s1_prod_d_reg <= s1_prod_d_next;
            s1_pert_reg   <= q_word.perturbed;
            s2_acc_reg    <= s2_acc_next;
            s2_pert_reg   <= s1_pert_reg;
            s3_cmd_reg    <= s3_cmd_next;
            s3_pert_reg   <= s2_pert_reg;
            s4_word_reg   <= s4_word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign empty  = !s4_valid_reg;
    assign result = s4_word_reg;

endmodule
